FILE: src/thdt_pkg.sv
// Package for the tap/hold/double-tap resolver: payload structs and codes.
// No dependencies.
package thdt_pkg;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_INTR    = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] BIND_TAP    = 2'd0;
  localparam logic [1:0] BIND_HOLD   = 2'd1;
  localparam logic [1:0] BIND_DOUBLE = 2'd2;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_HOLD   = 3'd4;

  localparam logic CFG_TERM  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  key_position;
    logic [31:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  action_position;
    logic [1:0]  binding_index;
    logic        transparent;
    logic        is_press;
    logic [31:0] action_time;
    logic        last_of_run;
  } out_item_t;

  // Raw action from the slot engine, before binding clamp.
  typedef struct packed {
    logic [7:0]  key;
    logic [1:0]  idx;
    logic        press;
    logic [31:0] time_ms;
    logic        last;
  } act_t;

  function automatic logic reached(input logic [31:0] t, input logic [31:0] d);
    logic [31:0] diff;
    diff = t - d;
    return ~diff[31];
  endfunction

endpackage

FILE: src/thdt_engine.sv
// Front part: accepts events, walks the slot table one slot per cycle while
// the queue has room, updates slot state, pushes raw actions. Depends on thdt_pkg.
module thdt_engine #(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  thdt_pkg::in_item_t    in_item,
  input  logic [15:0]           term,
  output logic                  act_push,
  output thdt_pkg::act_t        act_data,
  input  logic                  act_full
);
  import thdt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // Sequencer: idle, one keyed slot, slot walk, second half of a pair,
  // reopen after a late tap, and the final push carrying the last flag.
  localparam logic [2:0] ST_IDLE = 3'd0, ST_ONE = 3'd1, ST_SCAN = 3'd2,
                         ST_PAIR = 3'd3, ST_OPEN = 3'd4, ST_FLUSH = 3'd5;

  logic [SLOTS-1:0] used_r, used_nxt, held_r, held_nxt, armed_r, armed_nxt;
  logic [SLOTS-1:0] dset_r, dset_nxt;
  logic [7:0]  key_r [SLOTS];
  logic [7:0]  key_nxt [SLOTS];
  logic [2:0]  ph_r [SLOTS];
  logic [2:0]  ph_nxt [SLOTS];
  logic [31:0] dl_r [SLOTS];
  logic [31:0] dl_nxt [SLOTS];

  logic [2:0]    st_r, st_nxt;
  logic [2:0]    after_r, after_nxt;   // where to go once a pair is out
  in_item_t      ev_r, ev_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [4:0]    cnt_r, cnt_nxt;       // results kept for this item
  act_t          pend_r, pend_nxt;     // second half of a pair
  act_t          hold_r, hold_nxt;     // newest result, held until the next
  logic          hold_v_r, hold_v_nxt;

  // key lookup and free slot over the current table
  logic          hit, freef;
  logic [SW-1:0] hit_i, free_i;
  always_comb begin
    hit = 1'b0; hit_i = '0; freef = 1'b0; free_i = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && key_r[i] == ev_r.key_position) begin
        hit = 1'b1; hit_i = SW'(i);
      end
      if (!used_r[i]) begin
        freef = 1'b1; free_i = SW'(i);
      end
    end
  end

  assign in_stall = (st_r != ST_IDLE);

  function automatic act_t mk(input logic [7:0] k, input logic [1:0] b,
                              input logic p, input logic [31:0] t);
    act_t a;
    a.key = k; a.idx = b; a.press = p; a.time_ms = t; a.last = 1'b0;
    return a;
  endfunction

  always_comb begin
    logic [SW-1:0] s;
    logic          sel, clr, do_open, emit_v, due;
    logic [1:0]    n_act;
    act_t          a0, a1, emit_a;
    logic [31:0]   t;
    logic [7:0]    k;
    used_nxt = used_r; held_nxt = held_r; armed_nxt = armed_r; dset_nxt = dset_r;
    key_nxt = key_r; ph_nxt = ph_r; dl_nxt = dl_r;
    st_nxt = st_r; after_nxt = after_r; ev_nxt = ev_r; idx_nxt = idx_r;
    cnt_nxt = cnt_r; pend_nxt = pend_r; hold_nxt = hold_r; hold_v_nxt = hold_v_r;
    act_push = 1'b0; act_data = hold_r;
    s = (st_r == ST_SCAN) ? idx_r : hit_i;
    sel = 1'b0; clr = 1'b0; do_open = 1'b0; emit_v = 1'b0; emit_a = '0;
    n_act = 2'd0; a0 = '0; a1 = '0;
    t = ev_r.event_time;
    k = key_r[s];
    due = reached(t, dl_r[s]);
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          ev_nxt = in_item; idx_nxt = '0; cnt_nxt = '0; hold_v_nxt = 1'b0;
          st_nxt = (in_item.opcode == OP_INTR || in_item.opcode == OP_TICK)
                   ? ST_SCAN : ST_ONE;
        end
      end
      ST_ONE: begin
        if (!act_full) begin
          after_nxt = ST_FLUSH;
          if (hit) sel = 1'b1;
          else if (ev_r.opcode == OP_PRESS && freef) do_open = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!act_full) begin
          sel = 1'b1;
          idx_nxt = idx_r + SW'(1);
          after_nxt = (idx_r == LAST_SLOT) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_PAIR: begin
        if (!act_full) begin
          emit_v = 1'b1; emit_a = pend_r;
          st_nxt = after_r;
        end
      end
      ST_OPEN: begin
        if (!act_full) begin
          do_open = freef;
          st_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!act_full) begin
          if (hold_v_r) begin
            act_push = 1'b1; act_data.last = 1'b1; hold_v_nxt = 1'b0;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    // One slot step: state update plus up to two results.
    if (sel) begin
      case (ev_r.opcode)
        OP_PRESS: begin
          held_nxt[s] = 1'b1;
          if (ph_r[s] == PH_WAIT && due) begin
            // Late second press: the first tap resolves and a new gesture opens.
            n_act = 2'd2; clr = 1'b1; after_nxt = ST_OPEN;
            a0 = mk(k, BIND_TAP, 1'b1, dl_r[s]);
            a1 = mk(k, BIND_TAP, 1'b0, dl_r[s]);
          end else begin
            armed_nxt[s] = 1'b0;
            if (ph_r[s] == PH_WAIT) begin
              ph_nxt[s] = PH_SECOND;
              dl_nxt[s] = t + {16'd0, term};
              dset_nxt[s] = 1'b1; armed_nxt[s] = 1'b1;
            end
          end
        end
        OP_RELEASE: begin
          if (dset_r[s] && due && ph_r[s] == PH_FIRST) begin
            // Held past the deadline: hold press at the deadline, release now.
            n_act = 2'd2; clr = 1'b1;
            a0 = mk(k, BIND_HOLD, 1'b1, dl_r[s]);
            a1 = mk(k, BIND_HOLD, 1'b0, t);
          end else if (dset_r[s] && due && ph_r[s] == PH_SECOND) begin
            n_act = 2'd2; clr = 1'b1;
            a0 = mk(k, BIND_DOUBLE, 1'b1, dl_r[s]);
            a1 = mk(k, BIND_DOUBLE, 1'b0, dl_r[s]);
          end else begin
            held_nxt[s] = 1'b0;
            case (ph_r[s])
              PH_FIRST: begin
                ph_nxt[s] = PH_WAIT;
                dl_nxt[s] = t + {16'd0, term};
                dset_nxt[s] = 1'b1; armed_nxt[s] = 1'b1;
              end
              PH_SECOND: begin
                n_act = 2'd2; clr = 1'b1;
                a0 = mk(k, BIND_DOUBLE, 1'b1, t);
                a1 = mk(k, BIND_DOUBLE, 1'b0, t);
              end
              PH_HOLD: begin
                n_act = 2'd1; clr = 1'b1;
                a0 = mk(k, BIND_HOLD, 1'b0, t);
              end
              default: ;
            endcase
          end
        end
        OP_INTR: begin
          if (used_r[s] && k != ev_r.key_position) begin
            case (ph_r[s])
              PH_FIRST: begin
                armed_nxt[s] = 1'b0; ph_nxt[s] = PH_HOLD; n_act = 2'd1;
                a0 = mk(k, BIND_HOLD, 1'b1, t);
              end
              PH_WAIT: begin
                n_act = 2'd2; clr = 1'b1;
                a0 = mk(k, BIND_TAP, 1'b1, t);
                a1 = mk(k, BIND_TAP, 1'b0, t);
              end
              PH_SECOND: begin
                n_act = 2'd2; clr = 1'b1;
                a0 = mk(k, BIND_DOUBLE, 1'b1, t);
                a1 = mk(k, BIND_DOUBLE, 1'b0, t);
              end
              default: ;
            endcase
          end
        end
        default: begin
          if (used_r[s] && armed_r[s] && due) begin
            armed_nxt[s] = 1'b0;
            case (ph_r[s])
              PH_FIRST: begin
                if (held_r[s]) begin
                  ph_nxt[s] = PH_HOLD; n_act = 2'd1;
                  a0 = mk(k, BIND_HOLD, 1'b1, dl_r[s]);
                end
              end
              PH_WAIT: begin
                if (!held_r[s]) begin
                  n_act = 2'd2; clr = 1'b1;
                  a0 = mk(k, BIND_TAP, 1'b1, dl_r[s]);
                  a1 = mk(k, BIND_TAP, 1'b0, dl_r[s]);
                end
              end
              PH_SECOND: begin
                if (held_r[s]) begin
                  n_act = 2'd2; clr = 1'b1;
                  a0 = mk(k, BIND_DOUBLE, 1'b1, dl_r[s]);
                  a1 = mk(k, BIND_DOUBLE, 1'b0, dl_r[s]);
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end

    if (st_r == ST_ONE || st_r == ST_SCAN) begin
      if (!act_full) begin
        if (n_act != 2'd0) begin
          emit_v = 1'b1; emit_a = a0;
        end
        if (n_act == 2'd2) begin
          pend_nxt = a1; st_nxt = ST_PAIR;
        end else begin
          st_nxt = after_nxt;
        end
      end
    end

    if (clr) begin
      used_nxt[s] = 1'b0; key_nxt[s] = '0; ph_nxt[s] = PH_IDLE; held_nxt[s] = 1'b0;
      armed_nxt[s] = 1'b0; dl_nxt[s] = '0; dset_nxt[s] = 1'b0;
    end

    if (do_open) begin
      used_nxt[free_i] = 1'b1; key_nxt[free_i] = ev_r.key_position;
      held_nxt[free_i] = 1'b1; ph_nxt[free_i] = PH_FIRST;
      dl_nxt[free_i] = t + {16'd0, term};
      dset_nxt[free_i] = 1'b1; armed_nxt[free_i] = 1'b1;
    end

    // A new result pushes out the one held before it; results past the
    // sixteenth of an item are dropped.
    if (emit_v && cnt_r < 5'd16) begin
      cnt_nxt = cnt_r + 5'd1;
      if (hold_v_r) act_push = 1'b1;
      hold_nxt = emit_a; hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; after_r <= ST_FLUSH; used_r <= '0; held_r <= '0;
      armed_r <= '0; dset_r <= '0; cnt_r <= '0; idx_r <= '0; hold_v_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        key_r[i] <= '0; ph_r[i] <= PH_IDLE; dl_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt; after_r <= after_nxt; used_r <= used_nxt; held_r <= held_nxt;
      armed_r <= armed_nxt; dset_r <= dset_nxt; cnt_r <= cnt_nxt;
      idx_r <= idx_nxt; hold_v_r <= hold_v_nxt;
      key_r <= key_nxt; ph_r <= ph_nxt; dl_r <= dl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    pend_r <= pend_nxt;
    hold_r <= hold_nxt;
  end
endmodule

FILE: src/thdt_back.sv
// Back part: queue of raw actions, binding clamp, and the output register.
// The last flag arrives with each action from the front part. Depends on thdt_pkg.
module thdt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                act_push,
  input  thdt_pkg::act_t      act_data,
  output logic                act_full,
  input  logic [1:0]          bcount,
  output logic                out_valid,
  input  logic                out_stall,
  output thdt_pkg::out_item_t out_item
);
  import thdt_pkg::*;

  // Two-entry queue ahead of the output register.
  act_t       q_r [2];
  logic [1:0] n_r;
  logic       rd_r, wr_r;
  logic       pop;

  assign act_full = (n_r == 2'd2);
  assign pop = (n_r != 2'd0) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (act_push) begin
        q_r[wr_r] <= act_data; wr_r <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      n_r <= n_r + {1'b0, act_push} - {1'b0, pop};
      if (pop) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.action_position <= q_r[rd_r].key;
      out_item.transparent     <= (bcount == 2'd0);
      out_item.binding_index   <= (bcount == 2'd0) ? 2'd0 :
                                  (q_r[rd_r].idx < bcount) ? q_r[rd_r].idx :
                                  bcount - 2'd1;
      out_item.is_press        <= q_r[rd_r].press;
      out_item.action_time     <= q_r[rd_r].time_ms;
      out_item.last_of_run     <= q_r[rd_r].last;
    end
  end
endmodule

FILE: src/tap_hold_double_tap_resolver.sv
// Top level of the tap/hold/double-tap resolver: config registers, slot
// engine and action queue. Depends on thdt_pkg, thdt_engine, thdt_back.
//
//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_stall | in_item  (opcode, key, time)
//  out_    | output    | out_valid/out_stall | out_item (one binding action)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// A press or release works on its one keyed slot; a late second press also
// reopens a slot. An interrupt or tick walks every slot, one per cycle while
// the action queue has room; the second result of a pair is pushed from its
// own state. Each result is held back until the next one so the final one
// can carry the last flag. Reset is synchronous and clears all slots,
// loading a 200 ms tapping term and three bindings.
// A full action queue stalls the engine; output stalls back up the queue.
module tap_hold_double_tap_resolver #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  thdt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output thdt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import thdt_pkg::*;

  logic [15:0] term_r;
  logic [1:0]  bcount_r;
  logic        act_push, act_full;
  act_t        act_data;

  // The user must write configuration only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= 16'd200; bcount_r <= 2'd3;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TERM) term_r <= cfg_data;
      else bcount_r <= cfg_data[1:0];
    end
  end

  thdt_engine #(.SLOTS(SLOTS)) u_engine (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .term(term_r),
    .act_push, .act_data, .act_full
  );

  thdt_back u_back (
    .clk, .rst_n, .act_push, .act_data, .act_full, .bcount(bcount_r),
    .out_valid, .out_stall, .out_item
  );
endmodule

FILE: tb/sv/tb_thdt_checker.sv
// Checker for the tap/hold/double-tap resolver: watches both channels, predicts
// the binding actions of every accepted word and compares them. Depends on thdt_pkg.
module tb_thdt_checker #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  thdt_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  thdt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  action_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import thdt_pkg::*;

  logic [15:0] term;
  logic [1:0]  nbind;
  logic        s_used [SLOTS];
  logic [7:0]  s_key  [SLOTS];
  logic [2:0]  s_ph   [SLOTS];
  logic        s_held [SLOTS];
  logic        s_arm  [SLOTS];
  logic [31:0] s_dl   [SLOTS];
  logic        s_dset [SLOTS];

  out_item_t action_q[$];
  out_item_t run_buf[$];

  initial begin
    fail_count = 0;
    pending_count = 0;
    action_count = 0;
  end

  function automatic logic due(logic [31:0] t, logic [31:0] d);
    logic [31:0] diff;
    diff = t - d;
    return !diff[31];
  endfunction

  task automatic push_action(int s, logic [1:0] idx, logic press, logic [31:0] t);
    out_item_t a;
    if (run_buf.size() >= 16) return;
    a = '0;
    a.action_position = s_key[s];
    if (nbind == 2'd0) begin
      a.binding_index = 2'd0;
      a.transparent = 1'b1;
    end else begin
      a.binding_index = (idx < nbind) ? idx : nbind - 2'd1;
    end
    a.is_press = press;
    a.action_time = t;
    run_buf.push_back(a);
  endtask

  task automatic free_slot(int s);
    s_used[s] = 0; s_key[s] = '0; s_ph[s] = PH_IDLE; s_held[s] = 0;
    s_arm[s] = 0; s_dl[s] = '0; s_dset[s] = 0;
  endtask

  task automatic start_timer(int s, logic [31:0] t);
    s_dl[s] = t + {16'd0, term};
    s_dset[s] = 1;
    s_arm[s] = 1;
  endtask

  task automatic tap_out(int s, logic [1:0] idx, logic [31:0] t);
    push_action(s, idx, 1'b1, t);
    push_action(s, idx, 1'b0, t);
    free_slot(s);
  endtask

  task automatic hold_out(int s, logic [31:0] t);
    push_action(s, BIND_HOLD, 1'b1, t);
    s_ph[s] = PH_HOLD;
  endtask

  function automatic int slot_of(logic [7:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (s_used[i] && s_key[i] == k) return i;
    return -1;
  endfunction

  task automatic open_gesture(logic [7:0] k, logic [31:0] t);
    for (int i = 0; i < SLOTS; i++) begin
      if (!s_used[i]) begin
        s_used[i] = 1; s_key[i] = k; s_held[i] = 1; s_ph[i] = PH_FIRST;
        start_timer(i, t);
        return;
      end
    end
  endtask

  task automatic resolve_word(in_item_t w);
    int s;
    logic [31:0] t;
    logic [31:0] d;
    t = w.event_time;
    run_buf.delete();
    case (w.opcode)
      OP_PRESS: begin
        s = slot_of(w.key_position);
        if (s < 0) open_gesture(w.key_position, t);
        else begin
          s_held[s] = 1;
          if (s_ph[s] == PH_WAIT && due(t, s_dl[s])) begin
            tap_out(s, BIND_TAP, s_dl[s]);
            open_gesture(w.key_position, t);
          end else begin
            s_arm[s] = 0;
            if (s_ph[s] == PH_WAIT) begin
              s_ph[s] = PH_SECOND;
              start_timer(s, t);
            end
          end
        end
      end
      OP_RELEASE: begin
        s = slot_of(w.key_position);
        if (s >= 0) begin
          if (s_dset[s] && due(t, s_dl[s]) && s_ph[s] == PH_SECOND) begin
            s_arm[s] = 0;
            tap_out(s, BIND_DOUBLE, s_dl[s]);
          end else begin
            if (s_dset[s] && due(t, s_dl[s]) && s_ph[s] == PH_FIRST) begin
              s_arm[s] = 0;
              hold_out(s, s_dl[s]);
            end
            s_held[s] = 0;
            case (s_ph[s])
              PH_FIRST: begin
                s_ph[s] = PH_WAIT;
                start_timer(s, t);
              end
              PH_SECOND: begin
                s_arm[s] = 0;
                tap_out(s, BIND_DOUBLE, t);
              end
              PH_HOLD: begin
                push_action(s, BIND_HOLD, 1'b0, t);
                free_slot(s);
              end
              default: ;
            endcase
          end
        end
      end
      OP_INTR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (s_used[i] && s_key[i] != w.key_position) begin
            case (s_ph[i])
              PH_FIRST:  begin s_arm[i] = 0; hold_out(i, t); end
              PH_WAIT:   begin s_arm[i] = 0; tap_out(i, BIND_TAP, t); end
              PH_SECOND: begin s_arm[i] = 0; tap_out(i, BIND_DOUBLE, t); end
              default: ;
            endcase
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (s_used[i] && s_arm[i] && due(t, s_dl[i])) begin
            d = s_dl[i];
            s_arm[i] = 0;
            case (s_ph[i])
              PH_FIRST:  if (s_held[i]) hold_out(i, d);
              PH_WAIT:   if (!s_held[i]) tap_out(i, BIND_TAP, d);
              PH_SECOND: if (s_held[i]) tap_out(i, BIND_DOUBLE, d);
              default: ;
            endcase
          end
        end
      end
    endcase
    if (run_buf.size() > 0) run_buf[run_buf.size() - 1].last_of_run = 1'b1;
    foreach (run_buf[j]) action_q.push_back(run_buf[j]);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: action mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      term = 16'd200;
      nbind = 2'd3;
      for (int i = 0; i < SLOTS; i++) free_slot(i);
      action_q.delete();
      fail_count = 0;
      action_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TERM) term = cfg_data;
        else nbind = cfg_data[1:0];
      end
      if (in_valid && !in_stall) resolve_word(in_item);
      if (out_valid && !out_stall) begin
        action_count++;
        if (action_q.size() == 0) report_mismatch($sformatf("unexpected %p", out_item));
        else begin
          e = action_q.pop_front();
          if (out_item.action_position !== e.action_position)
            report_mismatch($sformatf("position %0d want %0d", out_item.action_position,
                                      e.action_position));
          if (out_item.binding_index !== e.binding_index)
            report_mismatch($sformatf("binding %0d want %0d", out_item.binding_index,
                                      e.binding_index));
          if (out_item.transparent !== e.transparent)
            report_mismatch($sformatf("transparent %0b want %0b", out_item.transparent,
                                      e.transparent));
          if (out_item.is_press !== e.is_press)
            report_mismatch($sformatf("press %0b want %0b", out_item.is_press, e.is_press));
          if (out_item.action_time !== e.action_time)
            report_mismatch($sformatf("time %0h want %0h", out_item.action_time,
                                      e.action_time));
          if (out_item.last_of_run !== e.last_of_run)
            report_mismatch($sformatf("last %0b want %0b", out_item.last_of_run,
                                      e.last_of_run));
        end
      end
    end
    pending_count = action_q.size();
  end
endmodule

FILE: tb/sv/tb_tap_hold_double_tap_resolver.sv
// Testbench top for the tap/hold/double-tap resolver: clock, reset, stimulus,
// configuration phases and verdict. Depends on thdt_pkg, the block and tb_thdt_checker.
module tb_tap_hold_double_tap_resolver;
  timeunit 1ns;
  timeprecision 1ps;
  import thdt_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int fail_count, pending_count, action_count;
  int cycle_count = 0;
  int words_sent = 0;
  int phases_done = 0;
  logic [31:0] now_ms = 32'd0;
  logic [7:0] keys [4];

  always #5 clk = ~clk;

  tap_hold_double_tap_resolver u_dut (.*);

  tb_thdt_checker u_chk (.*);

  // Overall watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls for a random number of cycles before each word it
  // takes; about a third of the time it draws zero, which gives runs with
  // no stalling at all.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Sends one word, with a random idle gap ahead of it, and waits until
  // the block takes it. Valid stays up after the handshake; the block
  // stalls until the next word or the next idle gap replaces it.
  task automatic send_word(logic [1:0] op, logic [7:0] k, logic [31:0] t);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{opcode: op, key_position: k, event_time: t};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Waits for every predicted action, then lets the engine's slot walk
  // finish before any register changes.
  task automatic drain_and_set(logic idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    phases_done++;
  endtask

  // A well-formed gesture on one key with random timing relative to the
  // tapping term, sometimes mixed with interrupts and ticks, or a noise word.
  task automatic random_gesture(logic [15:0] term);
    logic [7:0] k;
    int span;
    k = ($urandom_range(0, 3) == 0) ? 8'($urandom) : keys[$urandom_range(0, 3)];
    span = int'(term) + 2;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_word(OP_PRESS, k, now_ms);
        now_ms += $urandom_range(0, span);
        send_word(OP_RELEASE, k, now_ms);
        now_ms += $urandom_range(0, span);
        if ($urandom_range(0, 1)) begin
          send_word(OP_PRESS, k, now_ms);
          now_ms += $urandom_range(0, span);
          send_word(OP_RELEASE, k, now_ms);
        end
        now_ms += $urandom_range(0, span);
        send_word(OP_TICK, 8'($urandom), now_ms);
      end
      3, 4: begin
        send_word(OP_PRESS, k, now_ms);
        now_ms += $urandom_range(0, span);
        send_word(OP_TICK, 8'($urandom), now_ms);
        now_ms += $urandom_range(0, span);
        send_word(OP_RELEASE, k, now_ms);
      end
      5, 6: begin
        send_word(OP_PRESS, k, now_ms);
        now_ms += $urandom_range(0, span / 2);
        send_word(OP_INTR, keys[$urandom_range(0, 3)], now_ms);
        now_ms += $urandom_range(0, span);
        send_word(OP_RELEASE, k, now_ms);
      end
      default: begin
        // Noise: any opcode, any key, occasionally a time far away.
        if ($urandom_range(0, 7) == 0) now_ms = $urandom;
        send_word(2'($urandom), ($urandom_range(0, 1)) ? k : 8'($urandom), now_ms);
        now_ms += $urandom_range(0, span);
      end
    endcase
  endtask

  initial begin
    logic [15:0] term;
    keys = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings (200 ms, three bindings).
    send_word(OP_RELEASE, 8'h33, 32'd5);            // release of an unknown key
    send_word(OP_PRESS, 8'h00, 32'd10);             // single tap via tick
    send_word(OP_RELEASE, 8'h00, 32'd50);
    send_word(OP_TICK, 8'h00, 32'd100);             // early tick
    send_word(OP_TICK, 8'hFF, 32'd250);
    send_word(OP_PRESS, 8'hFF, 32'd300);            // double tap
    send_word(OP_RELEASE, 8'hFF, 32'd320);
    send_word(OP_PRESS, 8'hFF, 32'd340);
    send_word(OP_RELEASE, 8'hFF, 32'd360);
    send_word(OP_PRESS, 8'h11, 32'd400);            // hold, repeat press, release
    send_word(OP_PRESS, 8'h11, 32'd410);
    send_word(OP_TICK, 8'h00, 32'd700);             // stopped timer, nothing fires
    send_word(OP_RELEASE, 8'h11, 32'd900);
    send_word(OP_PRESS, 8'h20, 32'hFFFF_FF80);      // deadline across the wrap
    send_word(OP_TICK, 8'h00, 32'h0000_0050);
    send_word(OP_RELEASE, 8'h20, 32'h0000_0060);
    // Fill every slot, then one more press that finds no room; an interrupt then
    // resolves all slots but its own key's, within the cap of sixteen results; a second resolves that one.
    for (int i = 0; i < 9; i++) send_word(OP_PRESS, 8'(8'h80 + i), 32'd1000);
    for (int i = 0; i < 8; i++) send_word(OP_RELEASE, 8'(8'h80 + i), 32'd1010);
    send_word(OP_INTR, 8'h80, 32'd1020);
    send_word(OP_INTR, 8'h01, 32'd1030);

    // Random phases, each under different register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: term = 16'd1;
        1: term = 16'hFFFF;
        default: term = 16'($urandom_range(2, 400));
      endcase
      drain_and_set(CFG_TERM, term);
      drain_and_set(CFG_COUNT, 16'(ph % 4));
      now_ms = $urandom;
      for (int g = 0; g < 3; g++) random_gesture(term);
      // Release everything that might still be held, then flush by interrupt.
      foreach (keys[j]) send_word(OP_RELEASE, keys[j], now_ms);
      send_word(OP_INTR, 8'h77, now_ms);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d words over %0d register writes, checked %0d actions",
             words_sent, phases_done, action_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
